// ----- design/rgb_convolution_3x3_unit_defines.svh -----
// assertion macros used by the rgb convolution top level
`ifndef RGB_CONVOLUTION_3X3_UNIT_DEFINES_SVH
`define RGB_CONVOLUTION_3X3_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// implication that must hold at every clock edge outside reset
`define RC3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication checked in the next cycle
`define RC3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RC3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RC3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/rc3_pkg.sv -----
// package: shared types, constants and address codes of the convolution unit
package rc3_pkg;
	localparam int MaxLineWidth   = 2048;
	localparam int MaxFrameHeight = 2048;
	localparam int ColW = $clog2(MaxLineWidth);
	localparam int RowW = $clog2(MaxFrameHeight);
	localparam int DimW = 12;
	localparam int NumCells = 3;

	localparam logic [2:0] AddrKernelTop    = 3'd0;
	localparam logic [2:0] AddrKernelMiddle = 3'd1;
	localparam logic [2:0] AddrKernelBottom = 3'd2;
	localparam logic [2:0] AddrLineWidth    = 3'd3;
	localparam logic [2:0] AddrFrameHeight  = 3'd4;

	typedef logic [23:0] pixel_t;

	// flags that travel with one window position
	typedef struct packed {
		logic emit;
		logic line_end;
		logic frame_end;
	} tag_t;

	// partial sums of one column cell, one per channel
	typedef struct packed {
		logic signed [19:0] b;
		logic signed [19:0] g;
		logic signed [19:0] r;
	} psum_t;

	function automatic logic [7:0] clamp_u8(input logic signed [19:0] s);
		logic [7:0] v;
		if (s < 0) v = 8'd0;
		else if (s > 20'sd255) v = 8'hff;
		else v = s[7:0];
		return v;
	endfunction
endpackage

// ----- design/rc3_line_store.sv -----
// line store: two line memories giving the two pixels above the incoming one
module rc3_line_store import rc3_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [ColW-1:0] idx,
	input  pixel_t          bot,
	output pixel_t          top_s1,
	output pixel_t          mid_s1
);
	pixel_t older_mem [MaxLineWidth];
	pixel_t newer_mem [MaxLineWidth];
	logic            wb_pend_q;
	logic [ColW-1:0] wb_idx_q;

	// registered reads; the older line takes the old newer entry in the following cycle
	always_ff @(posedge clk) begin
		if (adv) begin
			top_s1 <= older_mem[idx];
			mid_s1 <= newer_mem[idx];
			newer_mem[idx] <= bot;
		end
		if (wb_pend_q) older_mem[wb_idx_q] <= mid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_pend_q <= 1'b0;
			wb_idx_q  <= '0;
		end else begin
			wb_pend_q <= adv;
			if (adv) wb_idx_q <= idx;
		end
	end
endmodule

// ----- design/rc3_column_cell.sv -----
// column cell: holds one window column and forms its weighted partial sums
module rc3_column_cell import rc3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  pixel_t      top_in,
	input  pixel_t      mid_in,
	input  pixel_t      bot_in,
	input  logic [23:0] k_top,
	input  logic [23:0] k_mid,
	input  logic [23:0] k_bot,
	input  logic [1:0]  sel,
	output pixel_t      top_q,
	output pixel_t      mid_q,
	output pixel_t      bot_q,
	output psum_t       psum
);
	logic signed [7:0] c0, c1, c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= '0;
			mid_q <= '0;
			bot_q <= '0;
		end else if (adv) begin
			top_q <= top_in;
			mid_q <= mid_in;
			bot_q <= bot_in;
		end
	end

	always_comb begin
		case (sel)
			2'd0: begin c0 = k_top[7:0];   c1 = k_mid[7:0];   c2 = k_bot[7:0];   end
			2'd1: begin c0 = k_top[15:8];  c1 = k_mid[15:8];  c2 = k_bot[15:8];  end
			2'd2: begin c0 = k_top[23:16]; c1 = k_mid[23:16]; c2 = k_bot[23:16]; end
			default: begin c0 = '0; c1 = '0; c2 = '0; end
		endcase
	end

	// column's weighted values per channel, max magnitude 3*255*128
	function automatic logic signed [19:0] col_sum(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic signed [7:0] w0, input logic signed [7:0] w1,
			input logic signed [7:0] w2);
		logic signed [19:0] s;
		s = $signed({1'b0, a}) * w0 + $signed({1'b0, b}) * w1 + $signed({1'b0, c}) * w2;
		return s;
	endfunction

	// 20 bits hold the full three-column total without overflow
	assign psum.r = col_sum(top_q[7:0],   mid_q[7:0],   bot_q[7:0],   c0, c1, c2);
	assign psum.g = col_sum(top_q[15:8],  mid_q[15:8],  bot_q[15:8],  c0, c1, c2);
	assign psum.b = col_sum(top_q[23:16], mid_q[23:16], bot_q[23:16], c0, c1, c2);
endmodule

// ----- design/rgb_convolution_3x3_unit.sv -----
// top level: 3x3 rgb convolution over a raster pixel stream
// One pixel transfer is accepted per clock. Each input pixel enters a row of three
// column cells: the incoming pixel and the two line-store pixels above it form the
// newest column, and the cells pass their columns left every transfer. A result
// passes the line-store read, the column register and the sum register and is then
// loaded into the output register; throughput is one pixel per clock, each line
// memory doing one read and one write a cycle. The input stalls only while the
// output register holds a result that the receiver does not take. Output frame is
// (line_width-2) by (frame_height-2); alpha is always 255. Width and height are
// saturated to 3..2048. Kernel bytes are signed, column 0 in the low byte.
`include "rgb_convolution_3x3_unit_defines.svh"
module rgb_convolution_3x3_unit import rc3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
	output logic        m_tlast,   // line_end
	output logic        m_tuser,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [23:0] k_top_q, k_mid_q, k_bot_q;
	logic [DimW-1:0] width_q, height_q;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic [DimW-1:0] w_eff, h_eff;
	logic adv, wr, last_col, last_row, in_xfer;
	logic [2:0] reg_idx;
	tag_t tag_s1, tag_s2, tag_s3, tag_now;
	logic v_s1, v_s2, v_s3;
	pixel_t bot_s1, top_s1, mid_s1;
	pixel_t ct [NumCells], cm [NumCells], cb [NumCells];
	psum_t ps [NumCells];
	logic signed [19:0] sum_r_s3, sum_g_s3, sum_b_s3;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr = psel && penable && pwrite && pready;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_top_q  <= 24'h00ff00;
			k_mid_q  <= 24'hff05ff;
			k_bot_q  <= 24'h00ff00;
			width_q  <= 12'd640;
			height_q <= 12'd480;
		end else if (wr) begin
			case (reg_idx)
				AddrKernelTop:    k_top_q  <= pwdata[23:0];
				AddrKernelMiddle: k_mid_q  <= pwdata[23:0];
				AddrKernelBottom: k_bot_q  <= pwdata[23:0];
				AddrLineWidth:    width_q  <= pwdata[11:0];
				AddrFrameHeight:  height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			AddrKernelTop:    prdata = {8'd0, k_top_q};
			AddrKernelMiddle: prdata = {8'd0, k_mid_q};
			AddrKernelBottom: prdata = {8'd0, k_bot_q};
			AddrLineWidth:    prdata = {20'd0, width_q};
			AddrFrameHeight:  prdata = {20'd0, height_q};
			default:          prdata = '0;
		endcase
	end

	// saturated frame bounds
	assign w_eff = (width_q < 12'd3) ? 12'd3 :
		(width_q > DimW'(MaxLineWidth)) ? DimW'(MaxLineWidth) : width_q;
	assign h_eff = (height_q < 12'd3) ? 12'd3 :
		(height_q > DimW'(MaxFrameHeight)) ? DimW'(MaxFrameHeight) : height_q;

	// the pipe moves whenever the output register is free or being emptied
	assign s_tready = !m_tvalid || m_tready;
	assign adv = s_tready;
	assign in_xfer = s_tvalid && s_tready;

	assign last_col = ({1'b0, col_q} + 13'd1) >= {1'b0, w_eff};
	assign last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, h_eff};
	assign tag_now.emit = (row_q >= RowW'(2)) && (col_q >= ColW'(2));
	assign tag_now.line_end = last_col;
	assign tag_now.frame_end = last_col && last_row;

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	rc3_line_store u_lines (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (in_xfer),
		.idx    (col_q),
		.bot    (s_tdata),
		.top_s1 (top_s1),
		.mid_s1 (mid_s1)
	);

	// stage 1 carries the incoming pixel beside the line-store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && tag_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			bot_s1 <= s_tdata;
			tag_s1 <= tag_now;
		end
		if (adv && v_s1) tag_s2 <= tag_s1;
		if (adv) tag_s3 <= tag_s2;
	end

	// chain of column cells: cell 2 takes the new column, cells shift left on a pixel
	for (genvar i = 0; i < NumCells; i++) begin : g_cell
		pixel_t ti, mi, bi;
		if (i == NumCells - 1) begin : g_head
			assign ti = top_s1;
			assign mi = mid_s1;
			assign bi = bot_s1;
		end else begin : g_link
			assign ti = ct[i+1];
			assign mi = cm[i+1];
			assign bi = cb[i+1];
		end
		rc3_column_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv && v_s1),
			.top_in (ti),
			.mid_in (mi),
			.bot_in (bi),
			.k_top  (k_top_q),
			.k_mid  (k_mid_q),
			.k_bot  (k_bot_q),
			.sel    (2'(i)),
			.top_q  (ct[i]),
			.mid_q  (cm[i]),
			.bot_q  (cb[i]),
			.psum   (ps[i])
		);
	end

	// sum register over the three cells
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_r_s3 <= ps[0].r + ps[1].r + ps[2].r;
			sum_g_s3 <= ps[0].g + ps[1].g + ps[2].g;
			sum_b_s3 <= ps[0].b + ps[1].b + ps[2].b;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			m_tdata <= {8'hff, clamp_u8(sum_b_s3), clamp_u8(sum_g_s3), clamp_u8(sum_r_s3)};
			m_tlast <= tag_s3.line_end;
			m_tuser <= tag_s3.frame_end;
		end
	end

	`RC3_ASSERT_NEXT(a_hold_out, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`RC3_ASSERT_IMPL(a_ready_free, clk, arst_n, !m_tvalid, s_tready)
	`RC3_ASSERT_IMPL(a_col_bound, clk, arst_n, width_q == $past(width_q), {1'b0, col_q} < w_eff)
	`RC3_ASSERT_NEXT(a_frame_wrap, clk, arst_n, in_xfer && last_col && last_row, {row_q, col_q} == '0)
endmodule

// ----- tb/tb.sv -----
// testbench for the 3x3 rgb convolution unit: stream stimulus, window predictor, checker
`timescale 1ns / 1ps
module tb;
	import rc3_pkg::*;

	localparam int CycleLimit = 2_000_000;
	localparam int RandomPixelTarget = 1230;
	localparam int SettleCycles = 8;

	// predictor of the convolution unit: its own copy of the line stores, the
	// window columns, the raster counters and the kernel
	class window_predictor;
		logic [23:0] kernel_rows [3];
		logic [11:0] width_reg;
		logic [11:0] height_reg;
		pixel_t      older_line [MaxLineWidth];
		pixel_t      newer_line [MaxLineWidth];
		pixel_t      window_cols [6];
		int unsigned col_pos;
		int unsigned row_pos;
		logic [33:0] pending_pixels [$];   // {frame_end, line_end, alpha, blue, green, red}
		int          mismatches;
		int          results_seen;

		function new();
			kernel_rows[0] = 24'h00ff00;
			kernel_rows[1] = 24'hff05ff;
			kernel_rows[2] = 24'h00ff00;
			width_reg = 12'd640;
			height_reg = 12'd480;
			foreach (window_cols[i]) window_cols[i] = '0;
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void set_reg(logic [2:0] addr, logic [31:0] value);
			case (addr)
				AddrKernelTop:    kernel_rows[0] = value[23:0];
				AddrKernelMiddle: kernel_rows[1] = value[23:0];
				AddrKernelBottom: kernel_rows[2] = value[23:0];
				AddrLineWidth:    width_reg = value[11:0];
				AddrFrameHeight:  height_reg = value[11:0];
				default: ;
			endcase
		endfunction

		function int unsigned saturate(logic [11:0] v, int unsigned hi);
			if (v < 3) return 3;
			if (v > hi) return hi;
			return v;
		endfunction

		// one channel of the clamped convolution over a 3x3 window
		function logic [7:0] conv_channel(pixel_t win [3][3], int shift);
			int sum;
			sum = 0;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					sum += int'(win[r][c][shift +: 8]) *
						int'($signed(kernel_rows[r][8*c +: 8]));
			if (sum < 0) return 8'd0;
			if (sum > 255) return 8'hff;
			return sum[7:0];
		endfunction

		// accepted input pixel: advance the window and queue the result it causes
		function void take_pixel(pixel_t px);
			int unsigned w, h, idx;
			pixel_t top, mid;
			pixel_t win [3][3];
			logic last_col, last_row;
			w = saturate(width_reg, MaxLineWidth);
			h = saturate(height_reg, MaxFrameHeight);
			idx = (col_pos < MaxLineWidth) ? col_pos : 0;
			top = older_line[idx];
			mid = newer_line[idx];
			last_col = (col_pos + 1 >= w);
			last_row = (row_pos + 1 >= h);
			if (row_pos >= 2 && col_pos >= 2) begin
				for (int r = 0; r < 3; r++) begin
					win[r][0] = window_cols[r];
					win[r][1] = window_cols[3 + r];
				end
				win[0][2] = top;
				win[1][2] = mid;
				win[2][2] = px;
				pending_pixels.push_back({last_col && last_row, last_col, 8'hff,
					conv_channel(win, 16), conv_channel(win, 8), conv_channel(win, 0)});
			end
			older_line[idx] = mid;
			newer_line[idx] = px;
			for (int i = 0; i < 3; i++) window_cols[i] = window_cols[3 + i];
			window_cols[3] = top;
			window_cols[4] = mid;
			window_cols[5] = px;
			if (last_col) begin
				col_pos = 0;
				row_pos = last_row ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		function void compare(string name, int exp_v, int act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				mismatches++;
			end
		endfunction

		// accepted output pixel against the oldest expected one
		function void match_pixel_out(logic [31:0] data, logic last, logic user);
			logic [33:0] exp_px;
			results_seen++;
			if (pending_pixels.size() == 0) begin
				$error("output pixel with none expected: data %h", data);
				mismatches++;
				return;
			end
			exp_px = pending_pixels.pop_front();
			compare("red_out", exp_px[7:0], data[7:0]);
			compare("green_out", exp_px[15:8], data[15:8]);
			compare("blue_out", exp_px[23:16], data[23:16]);
			compare("alpha_out", exp_px[31:24], data[31:24]);
			compare("line_end", exp_px[32], last);
			compare("frame_end", exp_px[33], user);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	window_predictor predictor = new();

	int cycle_count = 0;
	int pixels_sent = 0;
	int frames_sent = 0;
	int burst_left = 0;
	logic hold_toggle = 1'b0;

	rgb_convolution_3x3_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on the whole run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: stall pattern that changes mode now and then, plus a long hold-off
	// started from the stimulus by flipping hold_toggle
	int   rx_mode = 0;
	int   rx_mode_left = 0;
	int   rx_hold_left = 0;
	logic rx_hold_seen = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_toggle != rx_hold_seen) begin
				rx_hold_seen = hold_toggle;
				rx_hold_left = 400;
			end
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// output transfer monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			predictor.match_pixel_out(m_tdata, m_tlast, m_tuser);
	end

	// register write through the apb port; the unit must be idle
	task automatic write_reg(logic [2:0] addr, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {addr, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		predictor.set_reg(addr, value);
	endtask

	// one pixel transfer, with bursts and random gaps on the sending side
	task automatic send_pixel(pixel_t px);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		predictor.take_pixel(px);
		pixels_sent++;
	endtask

	// wait for every expected pixel, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (predictor.pending_pixels.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_channel(int style);
		case (style)
			0: return 8'($urandom_range(0, 255));
			1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
			default: return 8'($urandom_range(0, 15));
		endcase
	endfunction

	// full input frame; style 3 is a constant pixel given by fill
	task automatic send_frame(int style, pixel_t fill, int hold_at);
		int unsigned w, h;
		pixel_t px;
		w = predictor.saturate(predictor.width_reg, MaxLineWidth);
		h = predictor.saturate(predictor.height_reg, MaxFrameHeight);
		for (int i = 0; i < w * h; i++) begin
			if (i == hold_at) hold_toggle <= ~hold_toggle;
			if (style == 3) px = fill;
			else px = {pick_channel(style), pick_channel(style), pick_channel(style)};
			send_pixel(px);
		end
		frames_sent++;
	endtask

	task automatic set_frame(logic [23:0] k0, logic [23:0] k1, logic [23:0] k2,
			logic [11:0] w, logic [11:0] h);
		drain();
		write_reg(AddrKernelTop, {8'h00, k0});
		write_reg(AddrKernelMiddle, {8'h00, k1});
		write_reg(AddrKernelBottom, {8'h00, k2});
		write_reg(AddrLineWidth, {20'h0, w});
		write_reg(AddrFrameHeight, {20'h0, h});
	endtask

	function automatic logic [23:0] random_kernel_row();
		logic [23:0] k;
		if ($urandom_range(0, 1)) begin
			k = 24'($urandom());
		end else begin
			// small coefficients, from -2 to 2 in each kernel byte
			for (int c = 0; c < 3; c++) k[8*c +: 8] = 8'($urandom_range(0, 4) - 2);
		end
		return k;
	endfunction

	initial begin
		int unsigned rw, rh;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: largest positive kernel on white saturates high
		set_frame(24'h7f7f7f, 24'h7f7f7f, 24'h7f7f7f, 12'd3, 12'd3);
		send_frame(3, 24'hffffff, -1);
		// most negative kernel on white clamps to zero
		set_frame(24'h808080, 24'h808080, 24'h808080, 12'd3, 12'd3);
		send_frame(3, 24'hffffff, -1);
		// identity kernel, width and height below range saturate to three
		set_frame(24'h000000, 24'h000100, 24'h000000, 12'd0, 12'd2);
		send_frame(1, '0, -1);

		// random frames, mostly small
		while (pixels_sent < RandomPixelTarget + 27) begin
			rw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			rh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			set_frame(random_kernel_row(), random_kernel_row(), random_kernel_row(),
				12'(rw), 12'(rh));
			send_frame($urandom_range(0, 2), '0, -1);
		end

		// wider frame with a long receiver hold-off that fills the pipeline
		set_frame(random_kernel_row(), random_kernel_row(), random_kernel_row(),
			12'd40, 12'd8);
		send_frame(0, '0, 60);
		// back to the reset kernel on a small frame
		set_frame(24'h00ff00, 24'hff05ff, 24'h00ff00, 12'd5, 12'd4);
		send_frame(0, '0, -1);

		drain();
		$display("covered %0d frames, %0d input pixels, %0d output pixels checked",
			frames_sent, pixels_sent, predictor.results_seen);
		$display("sizes from saturated 3x3 up to 40-wide frames, clamps and a long stall");
		if (predictor.mismatches == 0 && predictor.pending_pixels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
